// ----- design/aat_pkg.sv -----
// Shared types, constants and command codes for the aging address table.
package aat_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int FILL_W      = $clog2(TABLE_SLOTS + 1);
    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 31;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 8;
    localparam int COUNT_W     = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEEN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREV  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_EXISTING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REUSED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] station_addr;
        logic              has_current;
        logic [TIME_W-1:0] now_ms;
        logic [WIN_W-1:0]  window_ms;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     found_addr;
        logic [COUNT_W-1:0]    active_count;
        logic [COUNT_W-1:0]    used_count;
    } out_item_t;

    // One table entry as held in memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] seen_ms;
    } entry_t;

    // Access request to the table memory
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_req_t;

endpackage

// ----- design/aat_table_ram.sv -----
// Entry memory of the aging address table: one write and one registered read port.
module aat_table_ram
    import aat_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_SLOTS];

    // Write the entry and register the read data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- design/aging_address_table.sv -----
// Top level of the aging address table: command sequencer around the entry memory.
//
// The table holds up to TABLE_SLOTS station addresses with their last-seen times in a
// single-port-read memory with a registered read port. Filled slots are always the
// lowest ones, so a fill count stands in for per-slot valid bits. Every transaction is
// handled one at a time: it is accepted, then one memory read is issued per filled slot
// in order (forward, or backward for a previous scan), with the data of each read
// checked in the cycle after the read, then a seen command writes its entry back and
// the result is delivered once the output register is free. Seen and scan commands
// stop at the first hit. No command overlaps another, so reads never meet the
// write-back of the same slot. in_ready is high whenever the sequencer is idle, even
// while the previous result still waits in the output register.
module aging_address_table
    import aat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic              eval_valid_reg, eval_valid_next;
    logic              eval_last_reg, eval_last_next;
    logic [SLOT_W-1:0] eval_idx_reg, eval_idx_next;
    logic              started_reg, started_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [ADDR_W-1:0] hit_addr_reg, hit_addr_next;
    logic [FILL_W-1:0] act_cnt_reg, act_cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    ram_req_t          ram_req;
    entry_t            rd_data;

    logic              in_fire;
    logic              out_free;
    logic              issuing;
    logic [SLOT_W-1:0] issue_idx;
    logic [FILL_W-1:0] rev_idx;
    logic [TIME_W-1:0] age;
    logic              entry_active;
    logic              entry_match;

    aat_table_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Pick the next slot to read: forward from 0, or backward from the last filled slot
    assign issuing   = (state_reg == S_SCAN) && (issue_cnt_reg < fill_reg);
    assign rev_idx   = fill_reg - issue_cnt_reg - FILL_W'(1);
    assign issue_idx = (item_reg.cmd == CMD_PREV) ? rev_idx[SLOT_W-1:0]
                                                  : issue_cnt_reg[SLOT_W-1:0];

    // Age test and address compare on the entry just read
    assign age          = item_reg.now_ms - rd_data.seen_ms;
    assign entry_active = age < {1'b0, item_reg.window_ms};
    assign entry_match  = (rd_data.addr == item_reg.station_addr);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        fill_next       = fill_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_valid_next = 1'b0;
        eval_last_next  = eval_last_reg;
        eval_idx_next   = eval_idx_reg;
        started_next    = started_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_addr_next   = hit_addr_reg;
        act_cnt_next    = act_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        ram_req         = '0;

        // Drop the result once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next      = in_data;
                    issue_cnt_next = '0;
                    started_next   = !in_data.has_current;
                    hit_next       = 1'b0;
                    hit_slot_next  = '0;
                    hit_addr_next  = '0;
                    act_cnt_next   = '0;
                    eval_last_next = 1'b0;
                    state_next     = (fill_reg == '0) ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next read
                if (issuing)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = issue_idx;
                    issue_cnt_next  = issue_cnt_reg + FILL_W'(1);
                    eval_valid_next = 1'b1;
                    eval_idx_next   = issue_idx;
                    eval_last_next  = (issue_cnt_reg + FILL_W'(1) == fill_reg);
                end

                // Check the entry read in the previous cycle
                if (eval_valid_reg)
                begin
                    unique case (item_reg.cmd)
                        CMD_SEEN:
                        begin
                            if (entry_match)
                            begin
                                hit_next      = 1'b1;
                                hit_slot_next = eval_idx_reg;
                            end
                        end
                        CMD_NEXT, CMD_PREV:
                        begin
                            if (started_reg && entry_active)
                            begin
                                hit_next      = 1'b1;
                                hit_slot_next = eval_idx_reg;
                                hit_addr_next = rd_data.addr;
                            end
                            else if (item_reg.has_current && entry_match)
                            begin
                                started_next = 1'b1;
                            end
                        end
                        CMD_COUNT:
                        begin
                            if (entry_active)
                            begin
                                act_cnt_next = act_cnt_reg + FILL_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (hit_next || eval_last_reg)
                    begin
                        state_next      = S_FINISH;
                        eval_valid_next = 1'b0;
                    end
                end
            end

            S_FINISH:
            begin
                // Write back and deliver once the output register is free
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next              = '0;
                    unique case (item_reg.cmd)
                        CMD_SEEN:
                        begin
                            ram_req.wr_en         = 1'b1;
                            ram_req.wr_data.addr  = item_reg.station_addr;
                            ram_req.wr_data.seen_ms = item_reg.now_ms;
                            out_data_next.found_addr = item_reg.station_addr;
                            if (hit_reg)
                            begin
                                ram_req.wr_addr      = hit_slot_reg;
                                out_data_next.status = ST_EXISTING;
                                out_data_next.slot   = SLOT_OUT_W'(hit_slot_reg);
                            end
                            else if (fill_reg < FILL_W'(TABLE_SLOTS))
                            begin
                                ram_req.wr_addr      = fill_reg[SLOT_W-1:0];
                                fill_next            = fill_reg + FILL_W'(1);
                                out_data_next.status = ST_NEW;
                                out_data_next.slot   = SLOT_OUT_W'(fill_reg);
                            end
                            else
                            begin
                                ram_req.wr_addr      = '0;
                                out_data_next.status = ST_REUSED;
                                out_data_next.slot   = '0;
                            end
                        end
                        CMD_NEXT, CMD_PREV:
                        begin
                            if (hit_reg)
                            begin
                                out_data_next.status     = ST_FOUND;
                                out_data_next.slot       = SLOT_OUT_W'(hit_slot_reg);
                                out_data_next.found_addr = hit_addr_reg;
                            end
                            else
                            begin
                                out_data_next.status = ST_NONE;
                            end
                        end
                        CMD_COUNT:
                        begin
                            out_data_next.active_count = COUNT_W'(act_cnt_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                    out_data_next.used_count = COUNT_W'(fill_next);
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            eval_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            eval_valid_reg <= eval_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        issue_cnt_reg <= issue_cnt_next;
        eval_last_reg <= eval_last_next;
        eval_idx_reg  <= eval_idx_next;
        started_reg   <= started_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        hit_addr_reg  <= hit_addr_next;
        act_cnt_reg   <= act_cnt_next;
        out_data_reg  <= out_data_next;
    end

    // Fill count never exceeds the table size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_SLOTS))
        else $error("fill count beyond table size");

    // Fill count never shrinks
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_reg >= $past(fill_reg))
        else $error("fill count decreased");

    // Reads and the write-back never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("read and write in the same cycle");

    // A pending result reports the current fill count
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.used_count == COUNT_W'(fill_reg))
        else $error("used count out of step with fill count");

    // No read data is checked while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !eval_valid_reg)
        else $error("entry check pending while idle");

endmodule

// ----- tb/sv/aging_address_table_tb.sv -----
// Self-checking testbench for the aging address table: directed and random commands.
module aging_address_table_tb;
    import aat_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_CMDS  = 1900;
    localparam int POOL_SIZE    = 24;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    aging_address_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Shadow copy of the table: filled slots are always 0 .. table_fill-1
    logic [ADDR_W-1:0] table_addr [TABLE_SLOTS];
    logic [TIME_W-1:0] table_seen [TABLE_SLOTS];
    int                table_fill = 0;

    in_item_t  pending_cmds[$];
    out_item_t expected_results[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        send_idle = 0;
    int        recv_stall = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit is_recent(logic [TIME_W-1:0] now, logic [TIME_W-1:0] seen,
                                     logic [WIN_W-1:0] win);
        logic [TIME_W-1:0] age;
        age = now - seen;
        return age < {1'b0, win};
    endfunction

    // Apply one command to the shadow table and return the result it must produce
    function automatic out_item_t table_apply(in_item_t c);
        out_item_t r;
        int        i;
        int        idx;
        int        hit;
        int        active;
        bit        got;
        bit        started;
        r = '0;
        case (c.cmd)
            CMD_SEEN:
            begin
                got = 1'b0;
                hit = 0;
                for (i = 0; i < table_fill; i++)
                begin
                    if (!got && table_addr[i] == c.station_addr)
                    begin
                        hit = i;
                        got = 1'b1;
                    end
                end
                if (got)
                    r.status = ST_EXISTING;
                else if (table_fill < TABLE_SLOTS)
                begin
                    hit = table_fill;
                    table_fill++;
                    r.status = ST_NEW;
                end
                else
                begin
                    hit = 0;
                    r.status = ST_REUSED;
                end
                table_addr[hit] = c.station_addr;
                table_seen[hit] = c.now_ms;
                r.slot = SLOT_OUT_W'(hit);
                r.found_addr = table_addr[hit];
            end
            CMD_NEXT, CMD_PREV:
            begin
                started = !c.has_current;
                got = 1'b0;
                for (i = 0; i < table_fill; i++)
                begin
                    idx = (c.cmd == CMD_NEXT) ? i : table_fill - 1 - i;
                    if (!got)
                    begin
                        if (started && is_recent(c.now_ms, table_seen[idx], c.window_ms))
                        begin
                            got = 1'b1;
                            r.status = ST_FOUND;
                            r.slot = SLOT_OUT_W'(idx);
                            r.found_addr = table_addr[idx];
                        end
                        else if (c.has_current && table_addr[idx] == c.station_addr)
                            started = 1'b1;
                    end
                end
            end
            default:
            begin
                active = 0;
                for (i = 0; i < table_fill; i++)
                begin
                    if (is_recent(c.now_ms, table_seen[i], c.window_ms))
                        active++;
                end
                r.active_count = COUNT_W'(active);
            end
        endcase
        r.used_count = COUNT_W'(table_fill);
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and calm stretches with none
    function automatic int draw_gap();
        int r;
        if ((cycle_count % 3000) < 600)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t make_cmd(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                          logic has_cur, logic [TIME_W-1:0] now,
                                          logic [WIN_W-1:0] win);
        in_item_t c;
        c.cmd = cmd;
        c.station_addr = addr;
        c.has_current = has_cur;
        c.now_ms = now;
        c.window_ms = win;
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: present queued commands, predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_idle <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_results.push_back(table_apply(in_data));
            if (send_idle > 0)
            begin
                send_idle <= send_idle - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                in_data <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                send_idle <= draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: stall at random, compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: %p", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(out_data.status));
                    check_field("slot", 64'(want.slot), 64'(out_data.slot));
                    check_field("found_addr", 64'(want.found_addr),
                                64'(out_data.found_addr));
                    check_field("active_count", 64'(want.active_count),
                                64'(out_data.active_count));
                    check_field("used_count", 64'(want.used_count),
                                64'(out_data.used_count));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall <= draw_gap();
            end
        end
    end

    // Build the stimulus, release reset, wait for the last result and report
    initial
    begin
        logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] clock_ms;
        logic [WIN_W-1:0]  win;
        logic [CMD_W-1:0]  cmd;
        logic              has_cur;
        int                k;
        int                r;

        // Empty table, extreme addresses and times, window edges, absent current entry
        pending_cmds.push_back(make_cmd(CMD_COUNT, '0, 1'b0, '0, '1));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '0, 1'b0, '0, '1));
        pending_cmds.push_back(make_cmd(CMD_PREV, '0, 1'b1, '0, '1));
        pending_cmds.push_back(make_cmd(CMD_SEEN, '0, 1'b0, '0, '1));
        pending_cmds.push_back(make_cmd(CMD_SEEN, '1, 1'b1, '1, '0));
        pending_cmds.push_back(make_cmd(CMD_SEEN, '0, 1'b0, 32'd100, '0));
        pending_cmds.push_back(make_cmd(CMD_SEEN, 48'h5555_5555_5555, 1'b0, 32'h8000_0000, '0));
        pending_cmds.push_back(make_cmd(CMD_SEEN, 48'hAAAA_AAAA_AAAA, 1'b0, 32'h7FFF_FFFF, '0));
        pending_cmds.push_back(make_cmd(CMD_COUNT, '0, 1'b0, 32'h8000_0010, '1));
        pending_cmds.push_back(make_cmd(CMD_COUNT, '1, 1'b1, 32'h8000_0010, '0));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '1, 1'b0, 32'h8000_0010, 31'h20));
        pending_cmds.push_back(make_cmd(CMD_NEXT, 48'h5555_5555_5555, 1'b1, 32'h8000_0010, 31'h20));
        pending_cmds.push_back(make_cmd(CMD_NEXT, 48'hAAAA_AAAA_AAAA, 1'b1, 32'h8000_0010, '1));
        pending_cmds.push_back(make_cmd(CMD_PREV, '0, 1'b0, 32'h8000_0010, 31'h20));
        pending_cmds.push_back(make_cmd(CMD_PREV, 48'hAAAA_AAAA_AAAA, 1'b1, 32'h8000_0010, '1));
        pending_cmds.push_back(make_cmd(CMD_PREV, 48'h0000_0000_1234, 1'b1, 32'h8000_0010, '1));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '0, 1'b1, 32'h8000_0010, '0));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '0, 1'b0, 32'h8000_0000, 31'd1));
        pending_cmds.push_back(make_cmd(CMD_PREV, '1, 1'b1, '1, 31'd1));
        pending_cmds.push_back(make_cmd(CMD_SEEN, '1, 1'b0, 32'd5, '1));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '0, 1'b1, 32'd10, 31'd6));
        pending_cmds.push_back(make_cmd(CMD_NEXT, '0, 1'b1, 32'd11, 31'd6));

        // Random traffic over a pool of stations a little larger than the table
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            addr_pool[k] = random_addr();
        clock_ms = $urandom();
        for (k = 0; k < RANDOM_CMDS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                clock_ms = clock_ms + $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, 50);

            r = $urandom_range(0, 99);
            if (r < 5)
                win = '0;
            else if (r < 55)
                win = WIN_W'($urandom_range(1, 200));
            else if (r < 85)
                win = WIN_W'($urandom_range(200, 5000));
            else if (r < 95)
                win = WIN_W'($urandom());
            else
                win = '1;

            r = $urandom_range(0, 99);
            cmd = (r < 40) ? CMD_SEEN : (r < 60) ? CMD_NEXT : (r < 80) ? CMD_PREV : CMD_COUNT;
            has_cur = 1'($urandom_range(0, 1));
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (cmd == CMD_SEEN)
            begin
                // a fresh station now and then pushes the full table into reusing slot 0
                if ($urandom_range(0, 9) < 2)
                begin
                    addr = random_addr();
                    addr_pool[$urandom_range(2, POOL_SIZE - 1)] = addr;
                end
            end
            else if (cmd != CMD_COUNT)
            begin
                has_cur = ($urandom_range(0, 3) != 0);
                if (!has_cur || $urandom_range(0, 9) == 0)
                    addr = random_addr();
            end
            else
                addr = random_addr();
            pending_cmds.push_back(make_cmd(cmd, addr, has_cur, clock_ms, win));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the traffic, then let the block settle
        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (expected_results.size() > 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/aat_pkg.sv
design/aat_table_ram.sv
design/aging_address_table.sv
tb/sv/aging_address_table_tb.sv
